// ----- src/m4i_pkg.sv -----
`default_nettype none
package m4i_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int VALUE_W        = 32;
   localparam int INDEX_W        = 4;
   localparam int THR_W          = 64;
   localparam logic [THR_W-1:0] THR_RESET = 64'd184467440737;
   localparam int NUM_ELEMS      = 16;

   // index of the i-th survivor when position s is struck out of 0..3
   function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] s);
      return (i >= s) ? i + 2'd1 : i;
   endfunction

endpackage
`default_nettype wire

// ----- src/m4i_ifs.sv -----
`default_nettype none
interface m4i_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [m4i_pkg::VALUE_W-1:0]  elem_value;
   logic        [m4i_pkg::INDEX_W-1:0]  elem_index;
   logic                                last_elem;
   modport source (output valid, elem_value, elem_index, last_elem, input ready);
   modport sink   (input valid, elem_value, elem_index, last_elem, output ready);
endinterface

interface m4i_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [m4i_pkg::VALUE_W-1:0]  inv_value;
   logic        [m4i_pkg::INDEX_W-1:0]  out_index;
   logic                                last_result;
   logic                                singular;
   modport source (output valid, inv_value, out_index, last_result, singular, input ready);
   modport sink   (input valid, inv_value, out_index, last_result, singular, output ready);
endinterface

interface m4i_csr_if;
   logic                              valid;
   logic                              ready;
   logic [m4i_pkg::THR_W-1:0]         data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- src/m4i_mult.sv -----
`default_nettype none
module m4i_mult #(
   parameter int ELEM_WIDTH = m4i_pkg::ELEM_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic signed [ELEM_WIDTH-1:0]      op_a,
   input  wire logic signed [ELEM_WIDTH+1:0]      op_b,
   output logic signed [2*ELEM_WIDTH+1:0]         prod_ff
);
   logic signed [2*ELEM_WIDTH+1:0] prod_in;

   assign prod_in = (2*ELEM_WIDTH+2)'(op_a * op_b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/m4i_div.sv -----
`default_nettype none
module m4i_div #(
   parameter int ELEM_WIDTH = m4i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m4i_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      start,
   input  wire logic [3*(ELEM_WIDTH+1)+2*FRAC_BITS-1:0]   num,
   input  wire logic [4*(ELEM_WIDTH+1)-1:0]               den,
   input  wire logic                                      neg,
   output logic                                           done_ff,
   output logic signed [ELEM_WIDTH-1:0]                   quot_ff
);
   localparam int NUM_W = 3*(ELEM_WIDTH+1) + 2*FRAC_BITS;
   localparam int DEN_W = 4*(ELEM_WIDTH+1);
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [ELEM_WIDTH:0] LIM_POS = ((ELEM_WIDTH+1)'(1) << (ELEM_WIDTH-1)) - 1'b1;

   logic                  busy_ff, busy_in, done_in, neg_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [NUM_W-1:0]      num_ff;
   logic [DEN_W-1:0]      den_ff, rem_ff, rem_in;
   logic [DEN_W:0]        rem_sh;
   logic [ELEM_WIDTH:0]   q_ff, q_in, lim, q_sat;
   logic                  ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_in  = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
      // top bit is sticky overflow
      q_in    = {q_ff[ELEM_WIDTH] | q_ff[ELEM_WIDTH-1], q_ff[ELEM_WIDTH-2:0], ge};
      lim     = neg_ff ? LIM_POS + 1'b1 : LIM_POS;
      q_sat   = (q_in > lim) ? lim : q_in;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W-1);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         neg_ff <= neg;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_in;
         q_ff   <= q_in;
         if (cnt_ff == '0) begin
            quot_ff <= neg_ff ? -q_sat[ELEM_WIDTH-1:0] : q_sat[ELEM_WIDTH-1:0];
         end
      end
   end
endmodule
`default_nettype wire

// ----- src/matrix4x4_inverse_adjugate.sv -----
`default_nettype none
// 4x4 inverse by adjugate, signed fixed point. Elements are loaded one transfer
// per cycle; the transfer with last_elem set starts the inversion and req_ready
// stays low until the final result transfer. Sixteen cofactors and the
// determinant are built exactly on one ELEM_WIDTH x (ELEM_WIDTH+2) multiplier,
// each multiply passing through operand fetch, multiply and accumulate states:
// 204 multiplies in all. The matrix is singular when the
// determinant is zero or its magnitude is below csr_ch.data (units of
// 2^-(4*FRAC_BITS)); one result with singular set is then given. Otherwise 16
// results follow in row-major order, each from a restoring divider that
// retires one quotient bit per cycle.
// Elements read by an inversion must have been loaded since reset.
module matrix4x4_inverse_adjugate #(
   parameter int ELEM_WIDTH = m4i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m4i_pkg::FRAC_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   m4i_req_if.sink    req_ch,
   m4i_rsp_if.source  rsp_ch,
   m4i_csr_if.sink    csr_ch
);
   localparam int CW    = ELEM_WIDTH + 1;
   localparam int BW    = CW + 1;
   localparam int PW    = 2*ELEM_WIDTH + 2;
   localparam int MIN_W = 2*CW;
   localparam int COF_W = 3*CW;
   localparam int ACC_W = 4*CW;
   localparam int NUM_W = COF_W + 2*FRAC_BITS;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LDA  = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_ACC  = 7'b0001000,
      ST_CHK  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [ELEM_WIDTH-1:0]             m_ff [m4i_pkg::NUM_ELEMS];
   logic signed [COF_W-1:0]           cof_ff [m4i_pkg::NUM_ELEMS];
   logic [m4i_pkg::THR_W-1:0]         thr_ff;
   logic [3:0]                        cidx_ff, cidx_in, o_ff, o_in;
   logic [1:0]                        term_ff, term_in, sub_ff, sub_in;
   logic                              det_ph_ff, det_ph_in, go_ff, go_in;
   logic                              sing_ff, sing_in, dneg_ff;
   logic signed [ELEM_WIDTH-1:0]      opa_ff;
   logic signed [MIN_W-1:0]           min_ff;
   logic signed [ACC_W-1:0]           acc_ff, acc_sum, prod_ext, prod_sh, mag;
   logic [ACC_W-1:0]                  mag_ff;
   logic signed [PW-1:0]              prod_ff;
   logic signed [BW-1:0]              op_b;
   logic [1:0]                        r, c, p, q, a_row, a_col, b_row, b_col, rd_row, rd_col;
   logic [ELEM_WIDTH-1:0]             m_rd;
   logic [3:0]                        cof_ridx;
   logic signed [COF_W-1:0]           cof_rd;
   logic [COF_W-1:0]                  cof_mag;
   logic                              acc_neg, cof_last, det_last, singular;
   logic                              div_done;
   logic signed [ELEM_WIDTH-1:0]      div_q;
   logic signed [m4i_pkg::VALUE_W-1:0] val_ff;
   logic [m4i_pkg::INDEX_W-1:0]       idx_ff;
   logic                              last_ff, sflag_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = (state_ff == ST_OUT);
   assign rsp_ch.inv_value   = val_ff;
   assign rsp_ch.out_index   = idx_ff;
   assign rsp_ch.last_result = last_ff;
   assign rsp_ch.singular    = sflag_ff;

   // operand addressing
   always_comb begin
      r = cidx_ff[3:2];
      c = cidx_ff[1:0];
      p = (term_ff == 2'd0) ? 2'd1 : 2'd0;
      q = (term_ff == 2'd2) ? 2'd1 : 2'd2;
      b_row = m4i_pkg::skip_idx(2'd2, r);
      b_col = (sub_ff == 2'd0) ? m4i_pkg::skip_idx(q, c) : m4i_pkg::skip_idx(p, c);
      if (det_ph_ff) begin
         a_row = 2'd0;
         a_col = cidx_ff[1:0];
      end else begin
         case (sub_ff)
            2'd0: begin
               a_row = m4i_pkg::skip_idx(2'd1, r);
               a_col = m4i_pkg::skip_idx(p, c);
            end
            2'd1: begin
               a_row = m4i_pkg::skip_idx(2'd1, r);
               a_col = m4i_pkg::skip_idx(q, c);
            end
            default: begin
               a_row = m4i_pkg::skip_idx(2'd0, r);
               a_col = m4i_pkg::skip_idx(term_ff, c);
            end
         endcase
      end
      rd_row = (state_ff == ST_LDA) ? a_row : b_row;
      rd_col = (state_ff == ST_LDA) ? a_col : b_col;
      m_rd   = m_ff[{rd_row, rd_col}];

      cof_ridx = (state_ff == ST_DIV) ? {o_ff[1:0], o_ff[3:2]} : {2'b00, cidx_ff[1:0]};
      cof_rd   = cof_ff[cof_ridx];
      cof_mag  = cof_rd[COF_W-1] ? -cof_rd : cof_rd;

      if (det_ph_ff) begin
         case (sub_ff)
            2'd0:    op_b = {1'b0, cof_rd[CW-1:0]};
            2'd1:    op_b = {1'b0, cof_rd[2*CW-1:CW]};
            default: op_b = {cof_rd[COF_W-1], cof_rd[COF_W-1:2*CW]};
         endcase
      end else begin
         case (sub_ff)
            2'd0, 2'd1: op_b = BW'(signed'(m_rd));
            2'd2:       op_b = {1'b0, min_ff[CW-1:0]};
            default:    op_b = {min_ff[MIN_W-1], min_ff[MIN_W-1:CW]};
         endcase
      end
   end

   m4i_mult #(.ELEM_WIDTH(ELEM_WIDTH)) u_mult (
      .clock   (clock),
      .en      (state_ff == ST_MUL),
      .op_a    (opa_ff),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // accumulate
   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      case (det_ph_ff ? sub_ff : {1'b0, sub_ff[0]})
         2'd0:    prod_sh = prod_ext;
         2'd1:    prod_sh = prod_ext <<< CW;
         default: prod_sh = prod_ext <<< (2*CW);
      endcase
      acc_neg  = !det_ph_ff && (term_ff[0] ^ cidx_ff[2] ^ cidx_ff[0]);
      acc_sum  = acc_neg ? acc_ff - prod_sh : acc_ff + prod_sh;
      cof_last = !det_ph_ff && sub_ff == 2'd3 && term_ff == 2'd2;
      det_last = det_ph_ff && sub_ff == 2'd2 && cidx_ff[1:0] == 2'd3;
      mag      = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
      singular = (acc_ff == '0) || (mag < ACC_W'(thr_ff));
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cidx_in   = cidx_ff;
      term_in   = term_ff;
      sub_in    = sub_ff;
      det_ph_in = det_ph_ff;
      o_in      = o_ff;
      go_in     = 1'b0;
      sing_in   = sing_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.last_elem) begin
               state_in  = ST_LDA;
               cidx_in   = '0;
               term_in   = '0;
               sub_in    = '0;
               det_ph_in = 1'b0;
            end
         end
         ST_LDA: state_in = ST_MUL;
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            state_in = ST_LDA;
            if (det_ph_ff) begin
               if (sub_ff == 2'd2) begin
                  sub_in  = '0;
                  cidx_in = cidx_ff + 1'b1;
               end else begin
                  sub_in = sub_ff + 1'b1;
               end
               if (det_last) begin
                  state_in = ST_CHK;
               end
            end else begin
               sub_in = sub_ff + 1'b1;
               if (sub_ff == 2'd3) begin
                  if (term_ff == 2'd2) begin
                     term_in = '0;
                     cidx_in = cidx_ff + 1'b1;
                     if (cidx_ff == 4'd15) begin
                        det_ph_in = 1'b1;
                     end
                  end else begin
                     term_in = term_ff + 1'b1;
                  end
               end
            end
         end
         ST_CHK: begin
            sing_in = singular;
            o_in    = '0;
            if (singular) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
               go_in    = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               if (sing_ff || o_ff == 4'd15) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DIV;
                  o_in     = o_ff + 1'b1;
                  go_in    = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cidx_ff   <= '0;
         term_ff   <= '0;
         sub_ff    <= '0;
         det_ph_ff <= 1'b0;
         o_ff      <= '0;
         go_ff     <= 1'b0;
         sing_ff   <= 1'b0;
         thr_ff    <= m4i_pkg::THR_RESET;
      end else begin
         state_ff  <= state_in;
         cidx_ff   <= cidx_in;
         term_ff   <= term_in;
         sub_ff    <= sub_in;
         det_ph_ff <= det_ph_in;
         o_ff      <= o_in;
         go_ff     <= go_in;
         sing_ff   <= sing_in;
         if (csr_ch.valid) begin
            thr_ff <= csr_ch.data;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_ch.valid && state_ff == ST_IDLE) begin
         m_ff[req_ch.elem_index] <= req_ch.elem_value[ELEM_WIDTH-1:0];
         acc_ff <= '0;
      end
      if (state_ff == ST_LDA) begin
         opa_ff <= m_rd;
      end
      if (state_ff == ST_ACC) begin
         if (!det_ph_ff && sub_ff == 2'd0) begin
            min_ff <= prod_ff;
         end else if (!det_ph_ff && sub_ff == 2'd1) begin
            min_ff <= min_ff - prod_ff;
         end else if (cof_last) begin
            cof_ff[cidx_ff] <= acc_sum[COF_W-1:0];
            acc_ff <= '0;
         end else begin
            acc_ff <= acc_sum;
         end
      end
      if (state_ff == ST_CHK) begin
         mag_ff   <= mag;
         dneg_ff  <= acc_ff[ACC_W-1];
         val_ff   <= '0;
         idx_ff   <= '0;
         last_ff  <= 1'b1;
         sflag_ff <= 1'b1;
      end
      if (state_ff == ST_DIV && div_done) begin
         val_ff   <= m4i_pkg::VALUE_W'(div_q);
         idx_ff   <= o_ff;
         last_ff  <= (o_ff == 4'd15);
         sflag_ff <= 1'b0;
      end
   end

   m4i_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff),
      .num     (NUM_W'(cof_mag) << (2*FRAC_BITS)),
      .den     (mag_ff),
      .neg     (cof_rd[COF_W-1] ^ dneg_ff),
      .done_ff (div_done),
      .quot_ff (div_q)
   );
endmodule
`default_nettype wire

// ----- src/m4i_check.sv -----
`default_nettype none
module m4i_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_value,
   input wire logic [3:0]  rsp_index,
   input wire logic        rsp_last,
   input wire logic        rsp_singular
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index))
      else $error("result dropped while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input open while result pending");

   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_last && rsp_value == 32'd0 && rsp_index == 4'd0)
      else $error("bad singular result");

   a_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("input reopened mid-matrix");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");
endmodule

bind matrix4x4_inverse_adjugate m4i_check u_m4i_check (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_value    (rsp_ch.inv_value),
   .rsp_index    (rsp_ch.out_index),
   .rsp_last     (rsp_ch.last_result),
   .rsp_singular (rsp_ch.singular)
);
`default_nettype wire

// ----- test/tb_matrix4x4_inverse_adjugate.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_matrix4x4_inverse_adjugate;

   typedef logic signed [255:0] wide_type;
   typedef struct packed {
      logic [m4i_pkg::VALUE_W-1:0] value;
      logic [m4i_pkg::INDEX_W-1:0] idx;
      logic                        last;
      logic                        sing;
   } inv_elem_type;

   localparam int STALL_PCT   = 22;
   localparam int WATCH_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   m4i_req_if req ();
   m4i_rsp_if rsp ();
   m4i_csr_if csr ();

   matrix4x4_inverse_adjugate dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [m4i_pkg::VALUE_W-1:0] mat_copy [m4i_pkg::NUM_ELEMS];
   logic [m4i_pkg::THR_W-1:0] thr_copy = m4i_pkg::THR_RESET;
   inv_elem_type inv_queue [$];
   int errors = 0;
   int n_elems = 0;
   int n_results = 0;
   int n_singular = 0;
   int n_matrices = 0;
   int quiet = 0;
   bit calm = 1'b0;

   function automatic wide_type elem_w(input int r, input int c);
      return wide_type'($signed(mat_copy[r*4+c]));
   endfunction

   function automatic wide_type cofactor_of(input int row, input int col);
      int rs[3];
      int cs[3];
      int n;
      wide_type a[3][3];
      wide_type t0, t1, t2, d;
      n = 0;
      for (int k = 0; k < 4; k++) if (k != row) begin rs[n] = k; n++; end
      n = 0;
      for (int k = 0; k < 4; k++) if (k != col) begin cs[n] = k; n++; end
      for (int k = 0; k < 9; k++) a[k/3][k%3] = elem_w(rs[k/3], cs[k%3]);
      t0 = a[1][1]*a[2][2] - a[1][2]*a[2][1];
      t1 = a[1][0]*a[2][2] - a[1][2]*a[2][0];
      t2 = a[1][0]*a[2][1] - a[1][1]*a[2][0];
      d = a[0][0]*t0 - a[0][1]*t1 + a[0][2]*t2;
      return ((row + col) & 1) ? -d : d;
   endfunction

   task automatic invert_stored();
      wide_type cof[16];
      wide_type det, c;
      logic [255:0] mag, num, q;
      logic [63:0] lim, qm;
      logic neg;
      inv_elem_type e;
      det = '0;
      for (int k = 0; k < 16; k++) cof[k] = cofactor_of(k >> 2, k & 3);
      for (int k = 0; k < 4; k++) det = det + elem_w(0, k) * cof[k];
      mag = det[255] ? -det : det;
      n_matrices++;
      if (det == 0 || mag < {192'b0, thr_copy}) begin
         e = '{value: '0, idx: '0, last: 1'b1, sing: 1'b1};
         inv_queue.push_back(e);
         return;
      end
      for (int k = 0; k < 16; k++) begin
         c   = cof[(k & 3)*4 + (k >> 2)];
         neg = c[255] != det[255];
         num = c[255] ? -c : c;
         num = num << (2*m4i_pkg::FRAC_BITS_DEF);
         q   = num / mag;
         lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
         qm  = (q > {192'b0, lim}) ? lim : q[63:0];
         e.value = neg ? -qm[31:0] : qm[31:0];
         e.idx   = m4i_pkg::INDEX_W'(k);
         e.last  = (k == 15);
         e.sing  = 1'b0;
         inv_queue.push_back(e);
      end
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result side: random stall and field check
   always @(posedge clock) begin
      inv_elem_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (inv_queue.size() == 0) begin
            report("unexpected transfer", 64'(rsp.inv_value), 64'd0);
         end else begin
            e = inv_queue.pop_front();
            n_results++;
            if (rsp.singular) n_singular++;
            if (rsp.inv_value !== e.value)
               report("inv_value", 64'(rsp.inv_value), 64'(e.value));
            if (rsp.out_index !== e.idx)
               report("out_index", 64'(rsp.out_index), 64'(e.idx));
            if (rsp.last_result !== e.last)
               report("last_result", 64'(rsp.last_result), 64'(e.last));
            if (rsp.singular !== e.sing)
               report("singular", 64'(rsp.singular), 64'(e.sing));
         end
      end
      rsp.ready <= calm || ($urandom_range(99) >= STALL_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCH_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", quiet);
         $display("tb_matrix4x4_inverse_adjugate failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_elem(input logic [31:0] v, input int idx, input bit last);
      if (!calm) begin
         while ($urandom_range(99) < STALL_PCT) begin
            req.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req.valid      <= 1'b1;
      req.elem_value <= v;
      req.elem_index <= m4i_pkg::INDEX_W'(idx);
      req.last_elem  <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      n_elems++;
      mat_copy[idx] = v;
      if (last) invert_stored();
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (inv_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [63:0] thr);
      drain();
      csr.valid <= 1'b1;
      csr.data  <= thr;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      thr_copy = thr;
   endtask

   task automatic test_identity();
      for (int k = 0; k < 16; k++)
         send_elem((k % 5 == 0) ? 32'h0001_0000 : 32'h0, k, k == 15);
   endtask

   task automatic test_saturation();
      write_threshold('0);
      send_elem(32'd2, 0, 0);
      send_elem(32'd2, 5, 0);
      send_elem(32'd2, 10, 0);
      send_elem(-32'sd2, 15, 1);
   endtask

   task automatic test_extremes();
      send_elem(32'h7fff_ffff, 0, 0);
      send_elem(32'h8000_0000, 5, 1);
   endtask

   task automatic test_singular();
      write_threshold(m4i_pkg::THR_RESET);
      for (int k = 0; k < 16; k += 5) send_elem(32'd1, k, k == 15);
      send_elem(32'd0, 15, 1);
   endtask

   function automatic logic [31:0] rand_elem(input int kind, input int k);
      case (kind)
         0: return $urandom;
         1: return 32'($urandom_range(0, 32'h40000)) - 32'h20000
                   + ((k % 5 == 0) ? 32'h0004_0000 : 32'h0);
         2: return 32'($urandom_range(0, 15)) - 32'd8;
         default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      endcase
   endfunction

   task automatic random_matrix();
      int kind;
      int dup;
      logic [31:0] vals[16];
      kind = $urandom_range(0, 4);
      foreach (vals[k]) vals[k] = rand_elem(kind == 4 ? 3 : kind, k);
      if (kind == 4) begin
         dup = $urandom_range(1, 3);
         for (int c = 0; c < 4; c++) vals[dup*4+c] = vals[c];
      end
      for (int k = 0; k < 16; k++) begin
         if ($urandom_range(99) < 5) send_elem($urandom, $urandom_range(0, 15), 0);
         send_elem(vals[k], k, k == 15);
      end
   endtask

   task automatic test_random(input int target);
      while (n_elems < target) begin
         random_matrix();
         if ($urandom_range(3) == 0)
            send_elem($urandom, $urandom_range(0, 15), 1);
      end
   endtask

   initial begin
      req.valid      = 1'b0;
      req.elem_value = '0;
      req.elem_index = '0;
      req.last_elem  = 1'b0;
      csr.valid      = 1'b0;
      csr.data       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity();
      test_saturation();
      test_extremes();
      test_singular();
      calm = 1'b1;
      test_random(n_elems + 40);
      calm = 1'b0;
      write_threshold(64'hffff_ffff_ffff_ffff);
      test_random(n_elems + 50);
      write_threshold({$urandom, $urandom} >> $urandom_range(0, 40));
      test_random(n_elems + 50);
      write_threshold(m4i_pkg::THR_RESET);
      test_random(220);
      drain();
      $display("covered %0d element transfers, %0d matrices, %0d inverse results (%0d singular)",
               n_elems, n_matrices, n_results, n_singular);
      if (errors == 0) begin
         $display("tb_matrix4x4_inverse_adjugate passed");
      end else begin
         $display("tb_matrix4x4_inverse_adjugate failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
